// ===== hw/rtl/pba_pkg.sv =====
// Shared types and codes for the pooled block allocator.
`default_nettype none

package pba_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_FREED     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NO_POOL   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_POOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SIZE    = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [3:0] pool_id;
    logic [5:0] block_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  result_pool;
    logic [5:0]  result_block;
    logic [21:0] byte_offset;
    logic        pool_released;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic open;
    logic free_chk;
    logic mul;
  } dp_cmd_t;

  typedef struct packed {
    logic order_empty;
    logic hit;
    logic scan_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pba_ctrl.sv =====
// Sequencing state machine of the pooled block allocator.
`default_nettype none

module pba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              opcode,
  input  wire pba_pkg::dp_stat_t stat,
  output pba_pkg::dp_cmd_t       cmd,
  output logic                   busy,
  output logic                   done
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_OPEN = 6'b000100,
    S_FREE = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (opcode == pba_pkg::OP_FREE) begin
            state_next = S_FREE;
          end else if (stat.order_empty) begin
            state_next = S_OPEN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_next = S_MUL;
        end else if (stat.scan_last) begin
          state_next = S_OPEN;
        end
      end
      S_OPEN:  state_next = S_MUL;
      S_FREE:  state_next = S_MUL;
      S_MUL:   state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.accept   = (state == S_IDLE) && start;
    cmd.scan     = (state == S_SCAN);
    cmd.open     = (state == S_OPEN);
    cmd.free_chk = (state == S_FREE);
    cmd.mul      = (state == S_MUL);
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

endmodule

`default_nettype wire

// ===== hw/rtl/pba_datapath.sv =====
// Pool bitmaps, pool order list, configuration and result registers.
`default_nettype none

module pba_datapath #(
  parameter int MAX_POOLS  = 16,
  parameter int MAX_BLOCKS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire pba_pkg::req_t                    req,
  input  wire pba_pkg::dp_cmd_t                 cmd,
  output pba_pkg::dp_stat_t                     stat,
  output pba_pkg::rsp_t                         rsp,
  input  wire logic                             cfg_we,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pba_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int PW = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int CW = $clog2(MAX_POOLS + 1);
  localparam int BW = MAX_BLOCKS;
  localparam logic [6:0]    NPOOLS7  = 7'(MAX_POOLS);
  localparam logic [6:0]    NBLOCKS7 = 7'(MAX_BLOCKS);
  localparam logic [CW-1:0] NPOOLS_C = CW'(MAX_POOLS);

  typedef struct packed {
    logic [6:0]    nblk;
    logic [BW-1:0] map;
  } entry_t;

  // Configuration.
  logic [6:0]  blocks_per_pool;
  logic [15:0] element_size;

  // Allocator state.
  logic [MAX_POOLS-1:0] pool_live;
  logic [PW-1:0]        pool_order [MAX_POOLS];
  logic [CW-1:0]        pool_count;
  entry_t               pool_mem [MAX_POOLS];

  // Per-transaction registers.
  entry_t        rd_data;
  logic [PW-1:0] cur_pool;
  logic [CW-1:0] scan_idx;
  logic [3:0]    req_pool;
  logic [5:0]    req_block;
  pba_pkg::rsp_t res;

  // Combinational helpers.
  logic [CW-1:0] nidx;
  logic [PW-1:0] next_pool;
  logic [6:0]    in_pool7;
  logic [6:0]    free_pool7;
  logic [PW-1:0] free_slot;
  logic          free_in_range;
  logic [BW-1:0] span;
  logic [BW-1:0] freebits;
  logic [BW-1:0] alloc_sel;
  logic [BW-1:0] blk_sel;
  logic [BW-1:0] new_map;
  logic [5:0]    low_free;
  logic          hit;
  logic          remain;
  logic          target_ok;
  logic [PW-1:0] open_slot;
  logic          slot_found;
  logic          no_pool;
  logic [6:0]    open_nblk;
  logic [6:0]    cur_pool7;
  logic [6:0]    open_slot7;
  logic [MAX_POOLS-1:0] shift_en;
  logic          seen;
  logic          rd_en;
  logic [PW-1:0] raddr;
  logic          mem_we;
  logic [PW-1:0] waddr;
  entry_t        wdata;

  assign nidx       = scan_idx + CW'(1);
  assign next_pool  = (nidx < NPOOLS_C) ? pool_order[nidx[PW-1:0]] : '0;
  assign in_pool7   = {3'b000, req.pool_id};
  assign free_pool7 = {3'b000, req_pool};
  assign free_slot  = free_pool7[PW-1:0];
  assign free_in_range = (free_pool7 < NPOOLS7);

  always_comb begin
    for (int k = 0; k < BW; k++) begin
      span[k]    = (7'(k) < rd_data.nblk);
      blk_sel[k] = (7'(k) == {1'b0, req_block});
    end
  end

  assign freebits = ~rd_data.map & span;
  assign hit      = |freebits;

  // Lowest free block of the pool under check.
  always_comb begin
    low_free = '0;
    for (int k = BW - 1; k >= 0; k--) begin
      if (freebits[k]) begin
        low_free = 6'(k);
      end
    end
    for (int k = 0; k < BW; k++) begin
      alloc_sel[k] = (7'(k) == {1'b0, low_free});
    end
  end

  assign new_map   = rd_data.map & ~blk_sel;
  assign remain    = |(new_map & span);
  assign target_ok = free_in_range && pool_live[free_slot] &&
                     ({1'b0, req_block} < rd_data.nblk);

  // Lowest pool slot that is not live.
  always_comb begin
    open_slot = '0;
    for (int k = MAX_POOLS - 1; k >= 0; k--) begin
      if (!pool_live[k]) begin
        open_slot = PW'(k);
      end
    end
  end

  assign slot_found = |(~pool_live);
  assign no_pool    = !slot_found || (pool_count >= NPOOLS_C);

  always_comb begin
    if (blocks_per_pool == 7'd0) begin
      open_nblk = 7'd1;
    end else if (blocks_per_pool > NBLOCKS7) begin
      open_nblk = NBLOCKS7;
    end else begin
      open_nblk = blocks_per_pool;
    end
  end

  // Entries at and after the released pool move down by one place.
  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < MAX_POOLS; j++) begin
      seen        = seen || ((pool_order[j] == free_slot) && (CW'(j) < pool_count));
      shift_en[j] = seen;
    end
  end

  assign cur_pool7  = 7'(cur_pool);
  assign open_slot7 = 7'(open_slot);

  // Memory port control.
  always_comb begin
    rd_en = cmd.accept || cmd.scan;
    if (cmd.accept) begin
      raddr = (req.opcode == pba_pkg::OP_ALLOC) ? pool_order[0] : in_pool7[PW-1:0];
    end else begin
      raddr = next_pool;
    end
    mem_we = 1'b0;
    waddr  = cur_pool;
    wdata  = rd_data;
    if (cmd.scan && hit) begin
      mem_we = 1'b1;
      waddr  = cur_pool;
      wdata  = '{nblk: rd_data.nblk, map: rd_data.map | alloc_sel};
    end else if (cmd.open && !no_pool) begin
      mem_we = 1'b1;
      waddr  = open_slot;
      wdata  = '{nblk: open_nblk, map: BW'(1)};
    end else if (cmd.free_chk && target_ok) begin
      mem_we = 1'b1;
      waddr  = free_slot;
      wdata  = '{nblk: rd_data.nblk, map: remain ? new_map : '0};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pool_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= pool_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_per_pool <= 7'd64;
      element_size    <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        pba_pkg::CFG_BLOCKS_PER_POOL: blocks_per_pool <= cfg_wdata[6:0];
        pba_pkg::CFG_ELEMENT_SIZE:    element_size    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_live  <= '0;
      pool_count <= '0;
    end else if (cmd.open && !no_pool) begin
      pool_live[open_slot] <= 1'b1;
      pool_count           <= pool_count + CW'(1);
    end else if (cmd.free_chk && target_ok && !remain) begin
      pool_live[free_slot] <= 1'b0;
      pool_count           <= pool_count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.open && !no_pool) begin
      pool_order[pool_count[PW-1:0]] <= open_slot;
    end else if (cmd.free_chk && target_ok && !remain) begin
      for (int j = 0; j < MAX_POOLS - 1; j++) begin
        if (shift_en[j]) begin
          pool_order[j] <= pool_order[j + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_pool  <= req.pool_id;
      req_block <= req.block_index;
      scan_idx  <= '0;
      cur_pool  <= pool_order[0];
    end else if (cmd.scan) begin
      scan_idx <= nidx;
      cur_pool <= next_pool;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && hit) begin
      res <= '{status: pba_pkg::ST_ALLOCATED, result_pool: cur_pool7[3:0],
               result_block: low_free, byte_offset: '0, pool_released: 1'b0};
    end else if (cmd.open) begin
      if (no_pool) begin
        res <= '{status: pba_pkg::ST_NO_POOL, result_pool: '0,
                 result_block: '0, byte_offset: '0, pool_released: 1'b0};
      end else begin
        res <= '{status: pba_pkg::ST_ALLOCATED, result_pool: open_slot7[3:0],
                 result_block: '0, byte_offset: '0, pool_released: 1'b0};
      end
    end else if (cmd.free_chk) begin
      if (target_ok) begin
        res <= '{status: pba_pkg::ST_FREED, result_pool: req_pool,
                 result_block: req_block, byte_offset: '0, pool_released: !remain};
      end else begin
        res <= '{status: pba_pkg::ST_NOT_FOUND, result_pool: req_pool,
                 result_block: req_block, byte_offset: '0, pool_released: 1'b0};
      end
    end else if (cmd.mul) begin
      if ((res.status == pba_pkg::ST_ALLOCATED) || (res.status == pba_pkg::ST_FREED)) begin
        res.byte_offset <= 22'(res.result_block * element_size);
      end else begin
        res.byte_offset <= '0;
      end
    end
  end

  assign stat.order_empty = (pool_count == '0);
  assign stat.hit         = hit;
  assign stat.scan_last   = (nidx >= pool_count);
  assign rsp              = res;

endmodule

`default_nettype wire

// ===== hw/rtl/pooled_block_allocator_core.sv =====
// Top level of the pooled block allocator: controller plus datapath.
//
//   Channel   Handshake          Payload
//   request   start / busy       req (opcode, pool_id, block_index)
//   result    done (strobe)      rsp (status, pool, block, offset, released)
//   config    cfg_we             cfg_index, cfg_wdata
//
// A free goes from start through the free check and offset multiply to done.
// An allocate scans the pool list, reading the pool bitmap memory one pool per
// cycle, and opens a new pool when every pool is full or the list is empty.
// Reset clears the pool list and sets blocks_per_pool to 64, element_size to 1.
// The result is shown for one cycle while busy; the block takes the next
// request in the cycle after done.
`default_nettype none

module pooled_block_allocator_core #(
  parameter int MAX_POOLS  = 16,
  parameter int MAX_BLOCKS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire pba_pkg::req_t                  req,
  output logic                                busy,
  output logic                                done,
  output pba_pkg::rsp_t                       rsp,
  input  wire logic                           cfg_we,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pba_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  pba_pkg::dp_cmd_t  cmd;
  pba_pkg::dp_stat_t stat;

  pba_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (req.opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  pba_datapath #(
    .MAX_POOLS  (MAX_POOLS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a transaction");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_not_found_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == pba_pkg::ST_NOT_FOUND)) |->
      ((rsp.byte_offset == '0) && !rsp.pool_released))
    else $error("failed free reports an offset or a release");

  a_release_on_free: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.pool_released) |-> (rsp.status == pba_pkg::ST_FREED))
    else $error("pool release reported on a non-free result");

endmodule

`default_nettype wire
